>>> hdl/dtms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtms_pkg
// Shared types, constants and helpers for the DNA trie marker scanner.
// ----------------------------------------------------------------------------
package dtms_pkg;

    localparam int NODES      = 4096;
    localparam int MARKERS    = 1024;
    localparam int TRIE_DEPTH = 32;

    localparam int NODE_W   = 12;               // width of a child field
    localparam int ADDR_W   = $clog2(NODES);
    localparam int HASH_W   = 32;
    localparam int MARKER_W = 10;
    localparam int SYM_W    = 8;
    localparam int DEPTH_W  = (TRIE_DEPTH > 1) ? $clog2(TRIE_DEPTH) : 1;

    localparam logic [SYM_W-1:0] SYM_N    = 8'h4E;   // 'N'
    localparam logic [SYM_W-1:0] SYM_BASE = 8'd65;   // 'A'

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_SEQ  = 2'd1,
        FUNC_END  = 2'd2
    } t_func;

    typedef struct packed {
        logic [3:0][NODE_W-1:0] children;   // index 0 C, 1 A, 2 G, 3 T
        logic [HASH_W-1:0]      hash;
        logic [MARKER_W-1:0]    marker;
    } t_node;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHILD,
        ST_NODE,
        ST_CLOSE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        Q_NONE,
        Q_HIT,
        Q_CLOSE,
        Q_DONE
    } t_q_cmd;

    typedef struct packed {
        t_q_cmd              cmd;
        logic [MARKER_W-1:0] marker;
        logic [HASH_W-1:0]   hash;
    } t_q_req;

    // slot = abs(((sym - 65) / 2) % 5 - 1); mod 5 via reciprocal 205/1024,
    // exact for the 7-bit quotient range
    function automatic logic [1:0] pick_slot(input logic [SYM_W-1:0] sym);
        logic [SYM_W-1:0] off;
        logic [6:0]       q;
        logic [14:0]      prod;
        logic [4:0]       quot;
        logic [6:0]       five_q;
        logic [6:0]       rem;
        off    = sym - SYM_BASE;
        q      = off[7:1];
        prod   = 15'(q) * 15'd205;
        quot   = prod[14:10];
        five_q = 7'(quot) * 7'd5;
        rem    = q - five_q;
        if (rem == 7'd0) begin
            pick_slot = 2'd1;
        end else begin
            pick_slot = 2'(rem - 7'd1);
        end
    endfunction

endpackage

>>> hdl/dna_trie_marker_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_trie_marker_scan
// Multi-pattern DNA marker matcher over a trie held in on-chip memory.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one command per transfer:
// load a trie node, a sequence byte, or end of sequence. Output channel
// (o_out_valid / i_out_stall) carries hits and the end-of-sequence marker;
// o_run_last flags the last result of a byte, o_seq_done the end result.
// Loads give no result. A sequence byte sweeps the walker store from the
// deepest depth to the root; at each depth the source node is read
// (ST_FETCH), then its child (ST_CHILD), and a reached node is checked for
// a hit (ST_NODE); a dead source walker skips both reads. The single read
// port of the trie memory sets this order (child read, then node read).
// A byte of 'N' or below 'A' kills all walkers and gives no result.
// End of sequence clears all walkers and gives one result.
// The output register lets the next transfer be accepted while a result
// waits; if the receiver stalls with a second hit pending, the sweep pauses.
// Reset clears walkers and the output side; trie contents are undefined
// until loaded.
// ----------------------------------------------------------------------------
module dna_trie_marker_scan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_func,
    input  logic [dtms_pkg::NODE_W-1:0]    i_node_addr,
    input  logic [dtms_pkg::NODE_W-1:0]    i_child_c,
    input  logic [dtms_pkg::NODE_W-1:0]    i_child_a,
    input  logic [dtms_pkg::NODE_W-1:0]    i_child_g,
    input  logic [dtms_pkg::NODE_W-1:0]    i_child_t,
    input  logic [dtms_pkg::HASH_W-1:0]    i_node_hash,
    input  logic [dtms_pkg::MARKER_W-1:0]  i_node_marker,
    input  logic [dtms_pkg::SYM_W-1:0]     i_symbol,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [dtms_pkg::MARKER_W-1:0]  o_hit_marker,
    output logic [dtms_pkg::HASH_W-1:0]    o_hit_hash,
    output logic                           o_run_last,
    output logic                           o_seq_done
);

    logic                        w_wr_en;
    logic [dtms_pkg::ADDR_W-1:0] w_wr_addr;
    dtms_pkg::t_node             w_wr_data;
    logic                        w_rd_en;
    logic [dtms_pkg::ADDR_W-1:0] w_rd_addr;
    dtms_pkg::t_node             w_rd_data;
    dtms_pkg::t_q_req            w_q_req;
    logic                        w_q_ready;

    dtms_trie_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    dtms_hit_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_q_req),
        .o_req_ready  (w_q_ready),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hit_marker (o_hit_marker),
        .o_hit_hash   (o_hit_hash),
        .o_run_last   (o_run_last),
        .o_seq_done   (o_seq_done)
    );

    dtms_scan_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_node_addr   (i_node_addr),
        .i_child_c     (i_child_c),
        .i_child_a     (i_child_a),
        .i_child_g     (i_child_g),
        .i_child_t     (i_child_t),
        .i_node_hash   (i_node_hash),
        .i_node_marker (i_node_marker),
        .i_symbol      (i_symbol),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_data     (w_wr_data),
        .o_rd_en       (w_rd_en),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_data),
        .o_q_req       (w_q_req),
        .i_q_ready     (w_q_ready)
    );

endmodule

>>> hdl/dtms_trie_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtms_trie_mem
// Trie node store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dtms_trie_mem (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [dtms_pkg::ADDR_W-1:0] i_wr_addr,
    input  dtms_pkg::t_node            i_wr_data,
    input  logic                       i_rd_en,
    input  logic [dtms_pkg::ADDR_W-1:0] i_rd_addr,
    output dtms_pkg::t_node            o_rd_data
);

    dtms_pkg::t_node r_mem [dtms_pkg::NODES];
    dtms_pkg::t_node r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/dtms_hit_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtms_hit_queue
// Holds one hit back so the last of a run can be flagged, then the output
// register towards the receiver.
// ----------------------------------------------------------------------------
module dtms_hit_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dtms_pkg::t_q_req               i_req,
    output logic                           o_req_ready,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [dtms_pkg::MARKER_W-1:0]  o_hit_marker,
    output logic [dtms_pkg::HASH_W-1:0]    o_hit_hash,
    output logic                           o_run_last,
    output logic                           o_seq_done
);

    logic                          r_pend_valid, n_pend_valid;
    logic [dtms_pkg::MARKER_W-1:0] r_pend_marker, n_pend_marker;
    logic [dtms_pkg::HASH_W-1:0]   r_pend_hash, n_pend_hash;
    logic                          r_out_valid, n_out_valid;
    logic [dtms_pkg::MARKER_W-1:0] r_out_marker, n_out_marker;
    logic [dtms_pkg::HASH_W-1:0]   r_out_hash, n_out_hash;
    logic                          r_out_last, n_out_last;
    logic                          r_out_done, n_out_done;
    logic                          w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_pend_valid  = r_pend_valid;
        n_pend_marker = r_pend_marker;
        n_pend_hash   = r_pend_hash;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_marker  = r_out_marker;
        n_out_hash    = r_out_hash;
        n_out_last    = r_out_last;
        n_out_done    = r_out_done;
        o_req_ready   = 1'b0;
        case (i_req.cmd)
            dtms_pkg::Q_HIT: begin
                o_req_ready = !r_pend_valid || w_out_free;
                if (o_req_ready) begin
                    if (r_pend_valid) begin
                        n_out_valid  = 1'b1;
                        n_out_marker = r_pend_marker;
                        n_out_hash   = r_pend_hash;
                        n_out_last   = 1'b0;
                        n_out_done   = 1'b0;
                    end
                    n_pend_valid  = 1'b1;
                    n_pend_marker = i_req.marker;
                    n_pend_hash   = i_req.hash;
                end
            end
            dtms_pkg::Q_CLOSE: begin
                o_req_ready = !r_pend_valid || w_out_free;
                if (o_req_ready && r_pend_valid) begin
                    n_out_valid  = 1'b1;
                    n_out_marker = r_pend_marker;
                    n_out_hash   = r_pend_hash;
                    n_out_last   = 1'b1;
                    n_out_done   = 1'b0;
                    n_pend_valid = 1'b0;
                end
            end
            dtms_pkg::Q_DONE: begin
                o_req_ready = w_out_free;
                if (o_req_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_marker = '0;
                    n_out_hash   = '0;
                    n_out_last   = 1'b1;
                    n_out_done   = 1'b1;
                end
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_marker <= n_pend_marker;
        r_pend_hash   <= n_pend_hash;
        r_out_marker  <= n_out_marker;
        r_out_hash    <= n_out_hash;
        r_out_last    <= n_out_last;
        r_out_done    <= n_out_done;
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit_marker = r_out_marker;
    assign o_hit_hash   = r_out_hash;
    assign o_run_last   = r_out_last;
    assign o_seq_done   = r_out_done;

endmodule

>>> hdl/dtms_scan_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtms_scan_ctrl
// Input handling, walker store and the per-depth sweep over the trie memory.
// ----------------------------------------------------------------------------
module dtms_scan_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_func,
    input  logic [dtms_pkg::NODE_W-1:0]    i_node_addr,
    input  logic [dtms_pkg::NODE_W-1:0]    i_child_c,
    input  logic [dtms_pkg::NODE_W-1:0]    i_child_a,
    input  logic [dtms_pkg::NODE_W-1:0]    i_child_g,
    input  logic [dtms_pkg::NODE_W-1:0]    i_child_t,
    input  logic [dtms_pkg::HASH_W-1:0]    i_node_hash,
    input  logic [dtms_pkg::MARKER_W-1:0]  i_node_marker,
    input  logic [dtms_pkg::SYM_W-1:0]     i_symbol,
    output logic                           o_wr_en,
    output logic [dtms_pkg::ADDR_W-1:0]    o_wr_addr,
    output dtms_pkg::t_node                o_wr_data,
    output logic                           o_rd_en,
    output logic [dtms_pkg::ADDR_W-1:0]    o_rd_addr,
    input  dtms_pkg::t_node                i_rd_data,
    output dtms_pkg::t_q_req               o_q_req,
    input  logic                           i_q_ready
);

    dtms_pkg::t_state              r_state, n_state;
    logic [dtms_pkg::DEPTH_W-1:0]  r_depth;
    logic [1:0]                    r_slot;
    logic [dtms_pkg::TRIE_DEPTH-1:0] r_live;
    logic [dtms_pkg::ADDR_W-1:0]   r_node [dtms_pkg::TRIE_DEPTH];

    logic                          w_accept;
    dtms_pkg::t_func               w_func;
    logic                          w_dead;
    logic [dtms_pkg::DEPTH_W-1:0]  w_prev;
    logic                          w_src_live;
    logic [dtms_pkg::ADDR_W-1:0]   w_src;
    logic [dtms_pkg::NODE_W-1:0]   w_ch;
    logic                          w_ch_ok;
    logic                          w_is_hit;
    logic                          w_last_depth;

    // control decoded by the output block
    logic                          w_start;
    logic                          w_clr_all;
    logic                          w_set;
    logic                          w_kill;
    logic                          w_advance;

    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_func       = dtms_pkg::t_func'(i_func);
    assign w_dead       = (i_symbol == dtms_pkg::SYM_N) || (i_symbol < dtms_pkg::SYM_BASE);
    assign w_prev       = r_depth - 1'b1;
    assign w_last_depth = (r_depth == '0);
    // depth 0 is always fed from the root
    assign w_src_live   = w_last_depth ? 1'b1 : r_live[w_prev];
    assign w_src        = w_last_depth ? '0 : r_node[w_prev];
    assign w_ch         = i_rd_data.children[r_slot];
    assign w_ch_ok      = (w_ch != '0) && (32'(w_ch) < dtms_pkg::NODES);
    assign w_is_hit     = (i_rd_data.hash != '0)
                          && (32'(i_rd_data.marker) < dtms_pkg::MARKERS);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dtms_pkg::ST_IDLE: begin
                if (w_accept && w_func == dtms_pkg::FUNC_SEQ && !w_dead) begin
                    n_state = dtms_pkg::ST_FETCH;
                end else if (w_accept && w_func == dtms_pkg::FUNC_END) begin
                    n_state = dtms_pkg::ST_DONE;
                end
            end
            dtms_pkg::ST_FETCH: begin
                if (w_src_live) begin
                    n_state = dtms_pkg::ST_CHILD;
                end else if (w_last_depth) begin
                    n_state = dtms_pkg::ST_CLOSE;
                end
            end
            dtms_pkg::ST_CHILD: begin
                if (w_ch_ok) begin
                    n_state = dtms_pkg::ST_NODE;
                end else if (w_last_depth) begin
                    n_state = dtms_pkg::ST_CLOSE;
                end else begin
                    n_state = dtms_pkg::ST_FETCH;
                end
            end
            dtms_pkg::ST_NODE: begin
                if (!w_is_hit || i_q_ready) begin
                    n_state = w_last_depth ? dtms_pkg::ST_CLOSE : dtms_pkg::ST_FETCH;
                end
            end
            dtms_pkg::ST_CLOSE: begin
                if (i_q_ready) begin
                    n_state = dtms_pkg::ST_IDLE;
                end
            end
            dtms_pkg::ST_DONE: begin
                if (i_q_ready) begin
                    n_state = dtms_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dtms_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall = 1'b1;
        o_wr_en    = 1'b0;
        o_wr_addr  = i_node_addr[dtms_pkg::ADDR_W-1:0];
        o_wr_data  = '{children: {i_child_t, i_child_g, i_child_a, i_child_c},
                       hash: i_node_hash, marker: i_node_marker};
        o_rd_en    = 1'b0;
        o_rd_addr  = w_src;
        o_q_req    = '{cmd: dtms_pkg::Q_NONE, marker: i_rd_data.marker,
                       hash: i_rd_data.hash};
        w_start    = 1'b0;
        w_clr_all  = 1'b0;
        w_set      = 1'b0;
        w_kill     = 1'b0;
        w_advance  = 1'b0;
        case (r_state)
            dtms_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (w_accept) begin
                    case (w_func)
                        dtms_pkg::FUNC_LOAD: begin
                            o_wr_en = (32'(i_node_addr) < dtms_pkg::NODES);
                        end
                        dtms_pkg::FUNC_SEQ: begin
                            // a dead byte kills every walker and yields nothing
                            w_clr_all = w_dead;
                            w_start   = !w_dead;
                        end
                        dtms_pkg::FUNC_END: begin
                            w_clr_all = 1'b1;
                        end
                        default: begin
                            w_clr_all = 1'b0;
                        end
                    endcase
                end
            end
            dtms_pkg::ST_FETCH: begin
                if (w_src_live) begin
                    o_rd_en = 1'b1;
                end else begin
                    w_kill    = 1'b1;
                    w_advance = !w_last_depth;
                end
            end
            dtms_pkg::ST_CHILD: begin
                o_rd_addr = w_ch[dtms_pkg::ADDR_W-1:0];
                if (w_ch_ok) begin
                    w_set   = 1'b1;
                    o_rd_en = 1'b1;
                end else begin
                    w_kill    = 1'b1;
                    w_advance = !w_last_depth;
                end
            end
            dtms_pkg::ST_NODE: begin
                if (w_is_hit) begin
                    o_q_req.cmd = dtms_pkg::Q_HIT;
                end
                w_advance = (!w_is_hit || i_q_ready) && !w_last_depth;
            end
            dtms_pkg::ST_CLOSE: begin
                o_q_req.cmd = dtms_pkg::Q_CLOSE;
            end
            dtms_pkg::ST_DONE: begin
                o_q_req.cmd = dtms_pkg::Q_DONE;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtms_pkg::ST_IDLE;
            r_live  <= '0;
        end else begin
            r_state <= n_state;
            if (w_clr_all) begin
                r_live <= '0;
            end else if (w_kill) begin
                r_live[r_depth] <= 1'b0;
            end else if (w_set) begin
                r_live[r_depth] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_depth <= dtms_pkg::DEPTH_W'(dtms_pkg::TRIE_DEPTH - 1);
            r_slot  <= dtms_pkg::pick_slot(i_symbol);
        end else if (w_advance) begin
            r_depth <= w_prev;
        end
        if (w_set) begin
            r_node[r_depth] <= w_ch[dtms_pkg::ADDR_W-1:0];
        end
    end

    // end of sequence leaves no live walker
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_func == dtms_pkg::FUNC_END) |=> (r_live == '0))
        else $error("walkers survive end of sequence");

    // a sweep only closes after the root depth
    a_close_at_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtms_pkg::ST_CLOSE) |-> (r_depth == '0))
        else $error("sweep closed early");

    // node data must hold while a hit waits for the queue
    a_node_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtms_pkg::ST_NODE && w_is_hit && !i_q_ready)
        |=> (r_state == dtms_pkg::ST_NODE && $stable(i_rd_data)))
        else $error("stalled hit lost its node data");

    // a walker never points back at the root
    a_live_nonroot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtms_pkg::ST_NODE) |-> (r_live[r_depth] && r_node[r_depth] != '0))
        else $error("live walker on root");

endmodule

>>> test/tb_dna_trie_marker_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dna_trie_marker_scan
// Self-checking bench for the trie marker scanner. A short table of loads,
// bytes and sequence ends comes first, then a deep run on a self-looping node
// and random tries and sequences. Every output transfer is compared against
// an in-bench walker model or a table row's typed expectation, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_dna_trie_marker_scan;

    localparam logic [1:0] FUNC_SPARE     = 2'd3;
    localparam int         IDLE_PCT       = 17;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         DRAIN_CYCLES   = 120;
    localparam int         ITEM_TARGET    = 380;

    typedef struct {
        logic [dtms_pkg::MARKER_W-1:0] marker;
        logic [dtms_pkg::HASH_W-1:0]   hash;
        logic                          run_last;
        logic                          seq_done;
    } t_result;

    typedef struct {
        logic [1:0]                       func;
        logic [dtms_pkg::NODE_W-1:0]      addr;
        logic [3:0][dtms_pkg::NODE_W-1:0] kids;   // 0 C, 1 A, 2 G, 3 T
        logic [dtms_pkg::HASH_W-1:0]      hash;
        logic [dtms_pkg::MARKER_W-1:0]    marker;
        logic [dtms_pkg::SYM_W-1:0]       sym;
        bit                               typed;
        t_result                          want;
    } t_cmd;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_stall;
    logic [1:0]                    i_func        = '0;
    logic [dtms_pkg::NODE_W-1:0]   i_node_addr   = '0;
    logic [dtms_pkg::NODE_W-1:0]   i_child_c     = '0;
    logic [dtms_pkg::NODE_W-1:0]   i_child_a     = '0;
    logic [dtms_pkg::NODE_W-1:0]   i_child_g     = '0;
    logic [dtms_pkg::NODE_W-1:0]   i_child_t     = '0;
    logic [dtms_pkg::HASH_W-1:0]   i_node_hash   = '0;
    logic [dtms_pkg::MARKER_W-1:0] i_node_marker = '0;
    logic [dtms_pkg::SYM_W-1:0]    i_symbol      = '0;
    logic                          o_out_valid;
    logic                          i_out_stall   = 1'b0;
    logic [dtms_pkg::MARKER_W-1:0] o_hit_marker;
    logic [dtms_pkg::HASH_W-1:0]   o_hit_hash;
    logic                          o_run_last;
    logic                          o_seq_done;

    // typed expectation travelling with the payload of a table row
    bit      note_typed = 1'b0;
    t_result note_want;

    bit  calm         = 1'b0;
    int  errors       = 0;
    int  items_sent   = 0;
    int  stuck_cycles = 0;

    bit                          node_loaded [dtms_pkg::NODES];
    logic [dtms_pkg::NODE_W-1:0] loaded_list [$];

    // walker model
    dtms_pkg::t_node             trie_img     [dtms_pkg::NODES];
    logic [dtms_pkg::NODE_W-1:0] walker_at    [dtms_pkg::TRIE_DEPTH];
    bit                          walker_alive [dtms_pkg::TRIE_DEPTH];
    t_result                     pending_results [$];

    wire in_fire  = i_rst_n && i_in_valid && !o_in_stall;
    wire out_fire = i_rst_n && o_out_valid && !i_out_stall;

    dna_trie_marker_scan dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_node_addr   (i_node_addr),
        .i_child_c     (i_child_c),
        .i_child_a     (i_child_a),
        .i_child_g     (i_child_g),
        .i_child_t     (i_child_t),
        .i_node_hash   (i_node_hash),
        .i_node_marker (i_node_marker),
        .i_symbol      (i_symbol),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit_marker  (o_hit_marker),
        .o_hit_hash    (o_hit_hash),
        .o_run_last    (o_run_last),
        .o_seq_done    (o_seq_done)
    );

    always #1 i_clk = ~i_clk;

    // C -> 0, A -> 1, G -> 2, T -> 3; only meaningful for bytes of 'A' and above
    function automatic int slot_of(input logic [dtms_pkg::SYM_W-1:0] sym);
        int q;
        q = ((int'(sym) - int'(dtms_pkg::SYM_BASE)) / 2) % 5;
        return (q == 0) ? 1 : q - 1;
    endfunction

    task automatic predict_scan(input logic [1:0] func,
                                input logic [dtms_pkg::NODE_W-1:0] addr,
                                input logic [3:0][dtms_pkg::NODE_W-1:0] kids,
                                input logic [dtms_pkg::HASH_W-1:0] hash,
                                input logic [dtms_pkg::MARKER_W-1:0] marker,
                                input logic [dtms_pkg::SYM_W-1:0] sym);
        logic [dtms_pkg::NODE_W-1:0] next_at    [dtms_pkg::TRIE_DEPTH];
        bit                          next_alive [dtms_pkg::TRIE_DEPTH];
        logic [dtms_pkg::NODE_W-1:0] src;
        logic [dtms_pkg::NODE_W-1:0] kid;
        bit                          src_alive;
        bit                          dead;
        int                          slot;
        int                          hits;
        int                          d;
        t_result                     r;
        hits = 0;
        case (func)
            dtms_pkg::FUNC_LOAD: begin
                trie_img[addr].children = kids;
                trie_img[addr].hash     = hash;
                trie_img[addr].marker   = marker;
            end
            dtms_pkg::FUNC_END: begin
                for (d = 0; d < dtms_pkg::TRIE_DEPTH; d++) begin
                    walker_alive[d] = 1'b0;
                    walker_at[d]    = '0;
                end
                r.marker   = '0;
                r.hash     = '0;
                r.run_last = 1'b1;
                r.seq_done = 1'b1;
                pending_results.push_back(r);
            end
            dtms_pkg::FUNC_SEQ: begin
                dead = (sym == dtms_pkg::SYM_N) || (sym < dtms_pkg::SYM_BASE);
                slot = slot_of(sym);
                // deepest walker first, so hits leave oldest first
                for (d = dtms_pkg::TRIE_DEPTH - 1; d >= 0; d--) begin
                    src_alive     = (d == 0) ? 1'b1 : walker_alive[d-1];
                    src           = (d == 0) ? '0 : walker_at[d-1];
                    next_at[d]    = '0;
                    next_alive[d] = 1'b0;
                    if (src_alive && !dead) begin
                        kid = trie_img[src].children[slot];
                        if (kid != '0) begin
                            next_at[d]    = kid;
                            next_alive[d] = 1'b1;
                            if (trie_img[kid].hash != '0) begin
                                r.marker   = trie_img[kid].marker;
                                r.hash     = trie_img[kid].hash;
                                r.run_last = 1'b0;
                                r.seq_done = 1'b0;
                                pending_results.push_back(r);
                                hits++;
                            end
                        end
                    end
                end
                walker_at    = next_at;
                walker_alive = next_alive;
                if (hits > 0) begin
                    pending_results[pending_results.size()-1].run_last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        int      depth_before;
        t_result want;
        if (in_fire) begin
            depth_before = pending_results.size();
            predict_scan(i_func, i_node_addr, {i_child_t, i_child_g, i_child_a, i_child_c},
                         i_node_hash, i_node_marker, i_symbol);
            if (note_typed) begin
                while (pending_results.size() > depth_before) begin
                    void'(pending_results.pop_back());
                end
                pending_results.push_back(note_want);
            end
        end
        if (out_fire) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: marker %0h hash %0h last %b done %b",
                         $time, o_hit_marker, o_hit_hash, o_run_last, o_seq_done);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit_marker", want.marker, o_hit_marker);
                check_field("hit_hash", want.hash, o_hit_hash);
                check_field("run_last", want.run_last, o_run_last);
                check_field("seq_done", want.seq_done, o_seq_done);
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (in_fire || out_fire) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_dna_trie_marker_scan: FAIL");
            $finish;
        end
    end

    function automatic t_cmd mk_row(input logic [1:0] func,
                                    input logic [dtms_pkg::NODE_W-1:0] addr, c, a, g, t,
                                    input logic [dtms_pkg::HASH_W-1:0] hash,
                                    input logic [dtms_pkg::MARKER_W-1:0] marker,
                                    input logic [dtms_pkg::SYM_W-1:0] sym);
        t_cmd r;
        r.func   = func;
        r.addr   = addr;
        r.kids   = {t, g, a, c};
        r.hash   = hash;
        r.marker = marker;
        r.sym    = sym;
        r.typed  = 1'b0;
        r.want   = '{default: '0};
        return r;
    endfunction

    function automatic t_cmd seq_row(input logic [dtms_pkg::SYM_W-1:0] sym);
        return mk_row(dtms_pkg::FUNC_SEQ, '0, '0, '0, '0, '0, '0, '0, sym);
    endfunction

    function automatic t_cmd typed_row(input t_cmd r,
                                       input logic [dtms_pkg::MARKER_W-1:0] marker,
                                       input logic [dtms_pkg::HASH_W-1:0] hash,
                                       input logic last, input logic done);
        t_cmd t;
        t                = r;
        t.typed          = 1'b1;
        t.want.marker    = marker;
        t.want.hash      = hash;
        t.want.run_last  = last;
        t.want.seq_done  = done;
        return t;
    endfunction

    function automatic t_cmd rand_cmd(input logic [1:0] func);
        t_cmd r;
        r = mk_row(func, dtms_pkg::NODE_W'($urandom_range(0, dtms_pkg::NODES - 1)),
                   dtms_pkg::NODE_W'($urandom_range(0, 4095)),
                   dtms_pkg::NODE_W'($urandom_range(0, 4095)),
                   dtms_pkg::NODE_W'($urandom_range(0, 4095)),
                   dtms_pkg::NODE_W'($urandom_range(0, 4095)),
                   $urandom, dtms_pkg::MARKER_W'($urandom_range(0, 1023)),
                   dtms_pkg::SYM_W'($urandom_range(0, 255)));
        return r;
    endfunction

    // children only ever point at nodes already loaded, so no walker reads
    // an unwritten node
    function automatic logic [dtms_pkg::NODE_W-1:0] pick_child(
            input logic [dtms_pkg::NODE_W-1:0] self);
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return '0;
        if (r < 35) return self;
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    function automatic logic [dtms_pkg::SYM_W-1:0] rand_base();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return dtms_pkg::SYM_N;
        if (r < 12) return dtms_pkg::SYM_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       return "C";
            1:       return "A";
            2:       return "G";
            default: return "T";
        endcase
    endfunction

    task automatic send_cmd(input t_cmd c);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= c.func;
        i_node_addr   <= c.addr;
        i_child_c     <= c.kids[0];
        i_child_a     <= c.kids[1];
        i_child_g     <= c.kids[2];
        i_child_t     <= c.kids[3];
        i_node_hash   <= c.hash;
        i_node_marker <= c.marker;
        i_symbol      <= c.sym;
        note_typed    <= c.typed;
        note_want     <= c.want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (c.func == dtms_pkg::FUNC_LOAD && !node_loaded[c.addr]) begin
            node_loaded[c.addr] = 1'b1;
            loaded_list.push_back(c.addr);
        end
        if (c.func != FUNC_SPARE) items_sent++;
    endtask

    initial begin
        t_cmd rows [$];
        t_cmd c;
        int   pick;
        int   len;
        int   s;

        // small trie: root C->1, A->4095, G->2, T->4095; 1 C->4095 without a
        // hash; 2 loops to itself on every base; 4095 is a leaf
        rows.push_back(typed_row(mk_row(dtms_pkg::FUNC_END, '0, '0, '0, '0, '0, '0, '0, '0),
                                 '0, '0, 1'b1, 1'b1));
        rows.push_back(mk_row(FUNC_SPARE, '1, '1, '1, '1, '1, '1, '1, '1));
        rows.push_back(mk_row(dtms_pkg::FUNC_LOAD, 12'd4095, '0, '0, '0, '0,
                              32'hFFFF_FFFF, 10'h3FF, '0));
        rows.push_back(mk_row(dtms_pkg::FUNC_LOAD, 12'd1, 12'd4095, '0, '0, '0,
                              '0, 10'h3FF, '0));
        rows.push_back(mk_row(dtms_pkg::FUNC_LOAD, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2,
                              32'd1, '0, '0));
        rows.push_back(mk_row(dtms_pkg::FUNC_LOAD, 12'd0, 12'd1, 12'd4095, 12'd2, 12'd4095,
                              32'hFFFF_FFFF, '0, '0));
        rows.push_back(typed_row(seq_row("A"), 10'h3FF, 32'hFFFF_FFFF, 1'b1, 1'b0));
        rows.push_back(seq_row(dtms_pkg::SYM_N));
        rows.push_back(typed_row(seq_row("T"), 10'h3FF, 32'hFFFF_FFFF, 1'b1, 1'b0));
        rows.push_back(seq_row(8'h00));
        // top byte folds onto the A slot
        rows.push_back(typed_row(seq_row(8'hFF), 10'h3FF, 32'hFFFF_FFFF, 1'b1, 1'b0));
        rows.push_back(seq_row("C"));
        rows.push_back(seq_row("C"));
        rows.push_back(seq_row("G"));
        rows.push_back(seq_row("G"));
        rows.push_back(seq_row(8'd64));
        rows.push_back(seq_row("Z"));
        rows.push_back(seq_row(8'h80));
        rows.push_back(typed_row(mk_row(dtms_pkg::FUNC_END, '0, '0, '0, '0, '0, '0, '0, '0),
                                 '0, '0, 1'b1, 1'b1));
        rows.push_back(typed_row(seq_row("G"), '0, 32'd1, 1'b1, 1'b0));
        rows.push_back(typed_row(mk_row(dtms_pkg::FUNC_END, '0, '0, '0, '0, '0, '0, '0, '0),
                                 '0, '0, 1'b1, 1'b1));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) send_cmd(rows[k]);

        // fill every walker depth on the self loop, then overflow it
        repeat (dtms_pkg::TRIE_DEPTH + 4) begin
            c     = rand_cmd(dtms_pkg::FUNC_SEQ);
            c.sym = "G";
            send_cmd(c);
        end
        send_cmd(rand_cmd(dtms_pkg::FUNC_END));

        while (items_sent < ITEM_TARGET) begin
            calm = (items_sent >= 200) && (items_sent < 270);
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                c = rand_cmd(dtms_pkg::FUNC_LOAD);
                for (s = 0; s < 4; s++) c.kids[s] = pick_child(c.addr);
                if ($urandom_range(0, 9) < 3) c.hash = '0;
                send_cmd(c);
            end else if (pick < 15) begin
                send_cmd(rand_cmd(FUNC_SPARE));
            end else begin
                len = $urandom_range(1, 24);
                repeat (len) begin
                    c     = rand_cmd(dtms_pkg::FUNC_SEQ);
                    c.sym = rand_base();
                    send_cmd(c);
                end
                // now and then a sequence runs on without its end
                if ($urandom_range(0, 9) != 0) send_cmd(rand_cmd(dtms_pkg::FUNC_END));
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_dna_trie_marker_scan: PASS");
        end else begin
            $display("tb_dna_trie_marker_scan: FAIL");
        end
        $finish;
    end

endmodule
